[rtl/core/iit_pkg.sv]
package iit_pkg;

  // opcode values of an input word
  localparam logic OP_INTERN = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_FOUND  = 2'd0,
    ST_ADDED  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADIDX = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RDDATA,
    S_DONE
  } state_e;

  // input word
  typedef struct packed {
    logic               opcode;
    logic signed [31:0] value_in;
    logic        [7:0]  entry_index;
  } in_t;

  // result word
  typedef struct packed {
    logic        [7:0]  index_out;
    logic signed [31:0] value_out;
    status_e            status;
  } out_t;

endpackage

[rtl/core/iit_store.sv]
module iit_store #(
  parameter int TABLE_DEPTH = 256,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] value_store_q [TABLE_DEPTH];
  logic [31:0] rdata_q;

  // single write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      value_store_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= value_store_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/iit_seq.sv]
module iit_seq #(
  parameter int TABLE_DEPTH = 256,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CW = $clog2(TABLE_DEPTH + 1),
  localparam int XW = (CW > 8) ? CW : 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  iit_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output iit_pkg::out_t  out_data_o,
  output logic           mem_we_o,
  output logic [AW-1:0]  mem_waddr_o,
  output logic [31:0]    mem_wdata_o,
  output logic [AW-1:0]  mem_raddr_o,
  input  logic [31:0]    mem_rdata_i
);

  iit_pkg::state_e    state_q, state_d;
  logic [CW-1:0]      fill_q, fill_d;
  logic [CW-1:0]      addr_q, addr_d;
  logic [AW-1:0]      cmp_idx_q, cmp_idx_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic signed [31:0] val_q, val_d;
  iit_pkg::out_t      res_q, res_d;
  logic               out_valid_q, out_valid_d;
  iit_pkg::out_t      out_q, out_d;

  logic in_acc;
  logic rd_ok;
  logic issue;
  logic hit;
  logic scan_miss;
  logic full;
  logic out_free;

  assign in_acc    = in_valid_i && in_ready_o;
  assign rd_ok     = XW'(in_data_i.entry_index) < XW'(fill_q);
  assign issue     = addr_q < fill_q;
  // shared comparator: one stored entry per cycle against the held value
  assign hit       = cmp_vld_q && (mem_rdata_i == val_q);
  assign scan_miss = !hit && !issue && !cmp_vld_q;
  assign full      = fill_q == CW'(TABLE_DEPTH);
  assign out_free  = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      iit_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_data_i.opcode == iit_pkg::OP_INTERN) begin
            state_d = iit_pkg::S_SCAN;
          end else if (rd_ok) begin
            state_d = iit_pkg::S_RDDATA;
          end else begin
            state_d = iit_pkg::S_DONE;
          end
        end
      end
      iit_pkg::S_SCAN: begin
        if (hit || scan_miss) begin
          state_d = iit_pkg::S_DONE;
        end
      end
      iit_pkg::S_RDDATA: begin
        state_d = iit_pkg::S_DONE;
      end
      iit_pkg::S_DONE: begin
        if (out_free) begin
          state_d = iit_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = iit_pkg::S_IDLE;
      end
    endcase
  end

  // datapath and memory control
  always_comb begin
    fill_d      = fill_q;
    addr_d      = addr_q;
    cmp_idx_d   = cmp_idx_q;
    cmp_vld_d   = 1'b0;
    val_d       = val_q;
    res_d       = res_q;
    in_ready_o  = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = AW'(fill_q);
    mem_wdata_o = val_q;
    mem_raddr_o = AW'(in_data_i.entry_index);
    case (state_q)
      iit_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_acc) begin
          val_d  = in_data_i.value_in;
          addr_d = '0;
          res_d.index_out = in_data_i.entry_index;
          res_d.value_out = '0;
          res_d.status    = iit_pkg::ST_BADIDX;
        end
      end
      iit_pkg::S_SCAN: begin
        mem_raddr_o = AW'(addr_q);
        // fetch the next filled entry while comparing the previous one
        if (issue && !hit) begin
          addr_d    = addr_q + CW'(1);
          cmp_idx_d = AW'(addr_q);
          cmp_vld_d = 1'b1;
        end
        if (hit) begin
          res_d.index_out = 8'(cmp_idx_q);
          res_d.value_out = val_q;
          res_d.status    = iit_pkg::ST_FOUND;
        end else if (scan_miss) begin
          res_d.value_out = val_q;
          if (full) begin
            res_d.index_out = '0;
            res_d.status    = iit_pkg::ST_FULL;
          end else begin
            mem_we_o        = 1'b1;
            fill_d          = fill_q + CW'(1);
            res_d.index_out = 8'(fill_q);
            res_d.status    = iit_pkg::ST_ADDED;
          end
        end
      end
      iit_pkg::S_RDDATA: begin
        res_d.value_out = mem_rdata_i;
        res_d.status    = iit_pkg::ST_FOUND;
      end
      iit_pkg::S_DONE: begin
        res_d = res_q;
      end
      default: begin
        res_d = res_q;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (state_q == iit_pkg::S_DONE && out_free) begin
      out_valid_d = 1'b1;
      out_d       = res_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= iit_pkg::S_IDLE;
      fill_q      <= '0;
      addr_q      <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      addr_q      <= addr_d;
      cmp_vld_q   <= cmp_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    val_q     <= val_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[rtl/core/integer_intern_table.sv]
// channel   signals                            word
// input     in_valid_i / in_ready_o            in_data_i  (opcode, value_in, entry_index)
// output    out_valid_o / out_ready_i          out_data_o (index_out, value_out, status)
//
// an intern walks the filled entries with the single comparator, one per cycle through
// the registered read port; a miss appends the value or reports full, a hit returns the
// matching index, and the result then goes out through done to out_valid_o.
// a filled-entry read passes through rddata to done; an unfilled index goes to done.
// reset clears the fill count and the control state; the value store is never cleared.
// one word in flight, in_ready_o high only in idle; a finished result waits in done until
// the output register is free, and the input is ready from the edge that moves it there.
module integer_intern_table #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  iit_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output iit_pkg::out_t out_data_o
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [31:0]   mem_rdata;

  // sequencer with the shared comparator
  iit_seq #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // value store
  iit_store #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
